/* rtl/tgcm_pkg.sv */
// shared types, constants and helpers for the triangle grid cell mask block
package tgcm_pkg;

  // default grid resolution per axis
  localparam int XZ_CELLS_DEF = 16;
  localparam int Y_CELLS_DEF  = 8;

  // bit offset of the z cells inside the xz mask
  localparam int Z_MASK_OFS = 16;

  // start value of the bounding box min/max search
  localparam logic signed [15:0] BOX_INIT = 16'sh7FBC;

  // surface flag tests
  localparam logic [31:0] FLAG_ANY  = 32'h0000_1080;
  localparam logic [31:0] FLAG_NONE = 32'h0801_0000;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_GRID_MIN_X = 3'd0,
    REG_GRID_MIN_Y = 3'd1,
    REG_GRID_MIN_Z = 3'd2,
    REG_GRID_MAX_X = 3'd3,
    REG_GRID_MAX_Y = 3'd4,
    REG_GRID_MAX_Z = 3'd5
  } cfg_idx_t;

  // one triangle beat as taken from the input channel
  typedef struct packed {
    logic signed [15:0] v0_x;
    logic signed [15:0] v0_y;
    logic signed [15:0] v0_z;
    logic signed [15:0] v1_x;
    logic signed [15:0] v1_y;
    logic signed [15:0] v1_z;
    logic signed [15:0] v2_x;
    logic signed [15:0] v2_y;
    logic signed [15:0] v2_z;
    logic [31:0]        surface_flags;
  } facet_t;

  // bounding box plus the zero-mask flag
  typedef struct packed {
    logic               flagged;
    logic signed [15:0] min_x;
    logic signed [15:0] min_y;
    logic signed [15:0] min_z;
    logic signed [15:0] max_x;
    logic signed [15:0] max_y;
    logic signed [15:0] max_z;
  } box_t;

  // floor of log2, evaluated at elaboration
  function automatic int floor_log2(input int n);
    int k;
    k = 0;
    for (int j = 1; j < 31; j++) begin
      if ((n >> j) != 0) begin
        k = j;
      end
    end
    return k;
  endfunction

endpackage

/* rtl/triangle_grid_cell_masks.sv */
// top level: triangle bounding box binning into uniform grid cell masks
//
//   channel | ports                         | direction
//   --------+-------------------------------+----------
//   input   | in_valid/in_ready, in_v*_*,   | in
//           | in_surface_flags              |
//   result  | out_valid/out_ready,          | out
//           | out_xz_mask, out_y_mask       |
//   config  | cfg_we, cfg_addr, cfg_wdata   | in
//
// one triangle per cycle while the result side does not stall; a result leaves
// through the input register, box register and mask register after its beat is taken
// reset clears the valid bits and the grid bounds; no clearing pass
// a stalled result holds the pipe, and in_ready follows out_ready in the
// same cycle so that no bubble is left behind a stall
module triangle_grid_cell_masks #(
  parameter int XZ_CELLS = tgcm_pkg::XZ_CELLS_DEF,
  parameter int Y_CELLS  = tgcm_pkg::Y_CELLS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_v0_x,
  input  logic signed [15:0] in_v0_y,
  input  logic signed [15:0] in_v0_z,
  input  logic signed [15:0] in_v1_x,
  input  logic signed [15:0] in_v1_y,
  input  logic signed [15:0] in_v1_z,
  input  logic signed [15:0] in_v2_x,
  input  logic signed [15:0] in_v2_y,
  input  logic signed [15:0] in_v2_z,
  input  logic [31:0]        in_surface_flags,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        out_xz_mask,
  output logic [7:0]         out_y_mask,
  // configuration
  input  logic               cfg_we,
  input  logic [2:0]         cfg_addr,
  input  logic [15:0]        cfg_wdata
);

  // grid bounds
  logic signed [15:0] grid_min_x_r, grid_min_y_r, grid_min_z_r;
  logic signed [15:0] grid_max_x_r, grid_max_y_r, grid_max_z_r;

  // pipeline registers
  logic             s1_valid_r, s2_valid_r, out_valid_r;
  tgcm_pkg::facet_t facet_r;
  tgcm_pkg::box_t   box_r;
  tgcm_pkg::box_t   box_nxt;
  logic [31:0]      xz_mask_r, xz_mask_nxt;
  logic [7:0]       y_mask_r, y_mask_nxt;

  logic [XZ_CELLS-1:0] x_mask, z_mask;
  logic [Y_CELLS-1:0]  y_cells;

  logic out_adv, s2_free, s1_free;

  // stall chain
  assign out_adv  = !out_valid_r || out_ready;
  assign s2_free  = !s2_valid_r || out_adv;
  assign s1_free  = !s1_valid_r || s2_free;
  assign in_ready = s1_free;

  // configuration writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_min_x_r <= '0;
      grid_min_y_r <= '0;
      grid_min_z_r <= '0;
      grid_max_x_r <= '0;
      grid_max_y_r <= '0;
      grid_max_z_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        tgcm_pkg::REG_GRID_MIN_X: grid_min_x_r <= $signed(cfg_wdata);
        tgcm_pkg::REG_GRID_MIN_Y: grid_min_y_r <= $signed(cfg_wdata);
        tgcm_pkg::REG_GRID_MIN_Z: grid_min_z_r <= $signed(cfg_wdata);
        tgcm_pkg::REG_GRID_MAX_X: grid_max_x_r <= $signed(cfg_wdata);
        tgcm_pkg::REG_GRID_MAX_Y: grid_max_y_r <= $signed(cfg_wdata);
        tgcm_pkg::REG_GRID_MAX_Z: grid_max_z_r <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  // bounding box of the registered triangle
  tgcm_box u_box (
    .facet (facet_r),
    .box   (box_nxt)
  );

  // per-axis cell masks from the registered box
  tgcm_axis #(.CELLS(XZ_CELLS)) u_axis_x (
    .origin (grid_min_x_r),
    .upper  (grid_max_x_r),
    .bmin   (box_r.min_x),
    .bmax   (box_r.max_x),
    .mask   (x_mask)
  );

  tgcm_axis #(.CELLS(Y_CELLS)) u_axis_y (
    .origin (grid_min_y_r),
    .upper  (grid_max_y_r),
    .bmin   (box_r.min_y),
    .bmax   (box_r.max_y),
    .mask   (y_cells)
  );

  tgcm_axis #(.CELLS(XZ_CELLS)) u_axis_z (
    .origin (grid_min_z_r),
    .upper  (grid_max_z_r),
    .bmin   (box_r.min_z),
    .bmax   (box_r.max_z),
    .mask   (z_mask)
  );

  // pack masks, zero for flagged surfaces
  always_comb begin
    if (box_r.flagged) begin
      xz_mask_nxt = '0;
      y_mask_nxt  = '0;
    end else begin
      xz_mask_nxt = {16'(z_mask), 16'(x_mask)};
      y_mask_nxt  = 8'(y_cells);
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_free) s1_valid_r <= in_valid;
      if (s2_free) s2_valid_r <= s1_valid_r;
      if (out_adv) out_valid_r <= s2_valid_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s1_free && in_valid) begin
      facet_r <= '{v0_x: in_v0_x, v0_y: in_v0_y, v0_z: in_v0_z,
                   v1_x: in_v1_x, v1_y: in_v1_y, v1_z: in_v1_z,
                   v2_x: in_v2_x, v2_y: in_v2_y, v2_z: in_v2_z,
                   surface_flags: in_surface_flags};
    end
    if (s2_free && s1_valid_r) begin
      box_r <= box_nxt;
    end
    if (out_adv && s2_valid_r) begin
      xz_mask_r <= xz_mask_nxt;
      y_mask_r  <= y_mask_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_xz_mask = xz_mask_r;
  assign out_y_mask  = y_mask_r;

endmodule

/* rtl/tgcm_box.sv */
// bounding box and surface flag test for one registered triangle
module tgcm_box (
  input  tgcm_pkg::facet_t facet,
  output tgcm_pkg::box_t   box
);

  function automatic logic signed [15:0] min3(
    input logic signed [15:0] a,
    input logic signed [15:0] b,
    input logic signed [15:0] c
  );
    logic signed [15:0] m;
    m = tgcm_pkg::BOX_INIT;
    if (a < m) m = a;
    if (b < m) m = b;
    if (c < m) m = c;
    return m;
  endfunction

  function automatic logic signed [15:0] max3(
    input logic signed [15:0] a,
    input logic signed [15:0] b,
    input logic signed [15:0] c
  );
    logic signed [15:0] m;
    m = -tgcm_pkg::BOX_INIT;
    if (m < a) m = a;
    if (m < b) m = b;
    if (m < c) m = c;
    return m;
  endfunction

  // surface is skipped when any trigger bit is set and no override bit is
  always_comb begin
    box.flagged = ((facet.surface_flags & tgcm_pkg::FLAG_ANY) != 32'd0) &&
                  ((facet.surface_flags & tgcm_pkg::FLAG_NONE) == 32'd0);
    box.min_x = min3(facet.v0_x, facet.v1_x, facet.v2_x);
    box.min_y = min3(facet.v0_y, facet.v1_y, facet.v2_y);
    box.min_z = min3(facet.v0_z, facet.v1_z, facet.v2_z);
    box.max_x = max3(facet.v0_x, facet.v1_x, facet.v2_x);
    box.max_y = max3(facet.v0_y, facet.v1_y, facet.v2_y);
    box.max_z = max3(facet.v0_z, facet.v1_z, facet.v2_z);
  end

endmodule

/* rtl/tgcm_axis.sv */
// cell overlap mask along one grid axis
module tgcm_axis #(
  parameter int CELLS = tgcm_pkg::XZ_CELLS_DEF
) (
  input  logic signed [15:0] origin,
  input  logic signed [15:0] upper,
  input  logic signed [15:0] bmin,
  input  logic signed [15:0] bmax,
  output logic [CELLS-1:0]   mask
);

  localparam int K = tgcm_pkg::floor_log2(CELLS);

  logic signed [16:0] span;
  logic signed [16:0] span_sh;
  logic [15:0]        step;
  logic signed [15:0] cell_edge [CELLS+1];

  // cell width: floor-shifted span plus one, wrapped to 16 bits
  assign span    = {upper[15], upper} - {origin[15], origin};
  assign span_sh = span >>> K;
  assign step    = span_sh[15:0] + 16'd1;

  // cell edges as constant multiples of the width, wrapping
  for (genvar g = 0; g <= CELLS; g++) begin : g_edge
    assign cell_edge[g] = $signed(origin + 16'(step * 16'(g)));
  end

  // overlap test per cell
  for (genvar g = 0; g < CELLS; g++) begin : g_cell
    assign mask[g] = (cell_edge[g+1] >= bmin) && (bmax >= cell_edge[g]);
  end

endmodule

/* rtl/tgcm_checker.sv */
// port-level checks for the triangle grid cell mask block, with bind
module tgcm_checker #(
  parameter int XZ_CELLS = tgcm_pkg::XZ_CELLS_DEF,
  parameter int Y_CELLS  = tgcm_pkg::Y_CELLS_DEF
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [31:0]        out_xz_mask,
  input logic [7:0]         out_y_mask
);

  localparam logic [15:0] XZ_USED = 16'((32'd1 << XZ_CELLS) - 32'd1);
  localparam logic [7:0]  Y_USED  = 8'((32'd1 << Y_CELLS) - 32'd1);

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled result stays and holds its masks
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_xz_mask) && $stable(out_y_mask))
    else $error("stalled result changed");

  // a ready sink never blocks the input side
  a_no_bubble: assert property (@(posedge clk) out_ready |-> in_ready)
    else $error("input stalled while output drains");

  // cells beyond the grid size never show
  a_unused_bits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_xz_mask[15:0] & ~XZ_USED) == 16'd0) &&
                  ((out_xz_mask[31:16] & ~XZ_USED) == 16'd0) &&
                  ((out_y_mask & ~Y_USED) == 8'd0))
    else $error("mask bit set outside the grid");

endmodule

bind triangle_grid_cell_masks tgcm_checker #(
  .XZ_CELLS (XZ_CELLS),
  .Y_CELLS  (Y_CELLS)
) u_tgcm_checker (.*);

/* tb/sv/tb_top.sv */
// self-checking testbench for the triangle grid cell mask block
`timescale 1ns / 100ps

module tb_top;
  import tgcm_pkg::*;

  localparam int XZ_N = XZ_CELLS_DEF;
  localparam int Y_N  = Y_CELLS_DEF;
  // floor of log2 of the cell counts
  localparam int XZ_SH = $clog2(XZ_N + 1) - 1;
  localparam int Y_SH  = $clog2(Y_N + 1) - 1;
  localparam int PIPE_DEPTH = 3;
  localparam int NUM_PHASES = 10;
  localparam int PHASE_ITEMS = 180;
  localparam int HOLD_CYCLES = 250;

  // register indexes the block does not decode
  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;

  typedef enum logic {ROW_TRI, ROW_CFG} row_kind_t;

  typedef struct packed {
    logic [31:0] xz;
    logic [7:0]  y;
  } cell_masks_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [2:0]  addr;
    logic [15:0] data;
    facet_t      facet;
    logic        typed;
    cell_masks_t masks;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] in_v0_x = '0, in_v0_y = '0, in_v0_z = '0;
  logic signed [15:0] in_v1_x = '0, in_v1_y = '0, in_v1_z = '0;
  logic signed [15:0] in_v2_x = '0, in_v2_y = '0, in_v2_z = '0;
  logic [31:0] in_surface_flags = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [31:0] out_xz_mask;
  logic [7:0] out_y_mask;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_addr = '0;
  logic [15:0] cfg_wdata = '0;

  // shadow of the grid bounds, indexed like the register map
  logic signed [15:0] grid_reg [6] = '{default: '0};
  cell_masks_t pending_masks[$];
  int err_cnt = 0;
  int send_quiet = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  triangle_grid_cell_masks #(
    .XZ_CELLS(XZ_N),
    .Y_CELLS (Y_N)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_v0_x         (in_v0_x),
    .in_v0_y         (in_v0_y),
    .in_v0_z         (in_v0_z),
    .in_v1_x         (in_v1_x),
    .in_v1_y         (in_v1_y),
    .in_v1_z         (in_v1_z),
    .in_v2_x         (in_v2_x),
    .in_v2_y         (in_v2_y),
    .in_v2_z         (in_v2_z),
    .in_surface_flags(in_surface_flags),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_xz_mask     (out_xz_mask),
    .out_y_mask      (out_y_mask),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata)
  );

  // directed rows: triangles as v0 xyz, v1 xyz, v2 xyz, flags
  dir_row_t dir_rows [40] = '{
    // reset grid: unit cells from zero upward, box clamped by the start values
    {ROW_TRI, 3'd0, 16'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
     16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000, 1'b1, 32'h0001_0001, 8'h01},
    {ROW_TRI, 3'd0, 16'd0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
     16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h0000_0000, 1'b1, 32'h0000_0000, 8'h00},
    {ROW_TRI, 3'd0, 16'd0, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
     16'h8000, 16'h8000, 16'h8000, 16'h8000, 32'h0000_0000, 1'b1, 32'h0000_0000, 8'h00},
    {ROW_TRI, 3'd0, 16'd0, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
     16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 8'hFF},
    // flagged surfaces
    {ROW_TRI, 3'd0, 16'd0, 16'h1234, 16'hEDCB, 16'h0001, 16'h7FFF, 16'h8000,
     16'h0000, 16'hAAAA, 16'h5555, 16'hFFFF, 32'h0000_1080, 1'b1, 32'h0000_0000, 8'h00},
    {ROW_TRI, 3'd0, 16'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
     16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0080, 1'b1, 32'h0000_0000, 8'h00},
    {ROW_TRI, 3'd0, 16'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
     16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0000_1000, 1'b1, 32'h0000_0000, 8'h00},
    {ROW_TRI, 3'd0, 16'd0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000,
     16'h8000, 16'h0000, 16'h0000, 16'h0000, 32'hF7FE_FFFF, 1'b1, 32'h0000_0000, 8'h00},
    // a blocking bit, or the lack of any trigger bit, clears the flag
    {ROW_TRI, 3'd0, 16'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
     16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0800_1080, 1'b1, 32'h0001_0001, 8'h01},
    {ROW_TRI, 3'd0, 16'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
     16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0001_1080, 1'b1, 32'h0001_0001, 8'h01},
    {ROW_TRI, 3'd0, 16'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
     16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'hFFFF_EF7F, 1'b1, 32'h0001_0001, 8'h01},
    // full span grid
    {ROW_CFG, REG_GRID_MIN_X, 16'h8000, 176'd0, 1'b0, 40'd0},
    {ROW_CFG, REG_GRID_MIN_Y, 16'h8000, 176'd0, 1'b0, 40'd0},
    {ROW_CFG, REG_GRID_MIN_Z, 16'h8000, 176'd0, 1'b0, 40'd0},
    {ROW_CFG, REG_GRID_MAX_X, 16'h7FFF, 176'd0, 1'b0, 40'd0},
    {ROW_CFG, REG_GRID_MAX_Y, 16'h7FFF, 176'd0, 1'b0, 40'd0},
    {ROW_CFG, REG_GRID_MAX_Z, 16'h7FFF, 176'd0, 1'b0, 40'd0},
    {ROW_TRI, 3'd0, 16'd0, 16'h7FBC, 16'h8044, 16'h7FBD, 16'h8043, 16'h7FBB,
     16'h0000, 16'h1234, 16'h8000, 16'h7FFF, 32'h0000_0000, 1'b0, 40'd0},
    {ROW_TRI, 3'd0, 16'd0, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
     16'h8000, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000, 1'b0, 40'd0},
    {ROW_TRI, 3'd0, 16'd0, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
     16'h8000, 16'h0000, 16'h0000, 16'h0000, 32'h0000_1080, 1'b1, 32'h0000_0000, 8'h00},
    // inverted bounds give a negative step
    {ROW_CFG, REG_GRID_MIN_X, 16'h7FFF, 176'd0, 1'b0, 40'd0},
    {ROW_CFG, REG_GRID_MIN_Y, 16'h7FFF, 176'd0, 1'b0, 40'd0},
    {ROW_CFG, REG_GRID_MIN_Z, 16'h7FFF, 176'd0, 1'b0, 40'd0},
    {ROW_CFG, REG_GRID_MAX_X, 16'h8000, 176'd0, 1'b0, 40'd0},
    {ROW_CFG, REG_GRID_MAX_Y, 16'h8000, 176'd0, 1'b0, 40'd0},
    {ROW_CFG, REG_GRID_MAX_Z, 16'h8000, 176'd0, 1'b0, 40'd0},
    {ROW_TRI, 3'd0, 16'd0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
     16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h0000_0000, 1'b0, 40'd0},
    {ROW_TRI, 3'd0, 16'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
     16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000, 1'b0, 40'd0},
    // narrow grids at the top, where cell edges wrap, and at the bottom
    {ROW_CFG, REG_GRID_MIN_X, 16'h7FC6, 176'd0, 1'b0, 40'd0},
    {ROW_CFG, REG_GRID_MAX_X, 16'h7FFF, 176'd0, 1'b0, 40'd0},
    {ROW_CFG, REG_GRID_MIN_Y, 16'h7FC6, 176'd0, 1'b0, 40'd0},
    {ROW_CFG, REG_GRID_MAX_Y, 16'h7FFF, 176'd0, 1'b0, 40'd0},
    {ROW_CFG, REG_GRID_MIN_Z, 16'h8000, 176'd0, 1'b0, 40'd0},
    {ROW_CFG, REG_GRID_MAX_Z, 16'h803F, 176'd0, 1'b0, 40'd0},
    {ROW_TRI, 3'd0, 16'd0, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF,
     16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 32'h0000_0000, 1'b0, 40'd0},
    {ROW_TRI, 3'd0, 16'd0, 16'h7FC8, 16'h7FF0, 16'h8010, 16'h0000, 16'h0000,
     16'h0000, 16'h7FD0, 16'h7FC7, 16'h8020, 32'h0000_0000, 1'b0, 40'd0},
    {ROW_TRI, 3'd0, 16'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
     16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000, 1'b0, 40'd0},
    // writes to undecoded indexes change nothing
    {ROW_CFG, REG_SPARE_A, 16'h1234, 176'd0, 1'b0, 40'd0},
    {ROW_CFG, REG_SPARE_B, 16'hFFFF, 176'd0, 1'b0, 40'd0},
    {ROW_TRI, 3'd0, 16'd0, 16'h7FFF, 16'h7FE0, 16'h8000, 16'h7FD0, 16'h7FFF,
     16'h8030, 16'h0100, 16'h0200, 16'h0300, 32'h0000_0000, 1'b0, 40'd0}
  };

  // clock
  always #10 clk = ~clk;

  // cells of one axis whose span meets the box
  function automatic logic [15:0] axis_cells(input logic signed [15:0] org, upr,
                                             input int ncells, shamt,
                                             input logic signed [15:0] bmin, bmax);
    int span;
    logic signed [15:0] step, lo, hi;
    logic [15:0] cells;
    span = int'(upr) - int'(org);
    step = 16'((span >>> shamt) + 1);
    lo = org;
    hi = step + org;
    cells = '0;
    for (int i = 0; i < ncells; i++) begin
      if (hi >= bmin && bmax >= lo) begin
        cells[i] = 1'b1;
      end
      hi = hi + step;
      lo = lo + step;
    end
    return cells;
  endfunction

  // expected masks for one triangle under the current grid
  function automatic cell_masks_t bin_triangle(input facet_t f);
    logic signed [15:0] crd [9];
    logic signed [15:0] bmin [3], bmax [3];
    logic [15:0] xc, yc, zc;
    cell_masks_t m;
    m = '0;
    if ((f.surface_flags & FLAG_ANY) != '0 && (f.surface_flags & FLAG_NONE) == '0) begin
      return m;
    end
    crd = '{f.v0_x, f.v0_y, f.v0_z, f.v1_x, f.v1_y, f.v1_z, f.v2_x, f.v2_y, f.v2_z};
    for (int a = 0; a < 3; a++) begin
      bmin[a] = BOX_INIT;
      bmax[a] = -BOX_INIT;
    end
    for (int v = 0; v < 3; v++) begin
      for (int a = 0; a < 3; a++) begin
        if (bmax[a] < crd[v * 3 + a]) bmax[a] = crd[v * 3 + a];
        if (crd[v * 3 + a] < bmin[a]) bmin[a] = crd[v * 3 + a];
      end
    end
    xc = axis_cells(grid_reg[REG_GRID_MIN_X], grid_reg[REG_GRID_MAX_X], XZ_N, XZ_SH,
                    bmin[0], bmax[0]);
    yc = axis_cells(grid_reg[REG_GRID_MIN_Y], grid_reg[REG_GRID_MAX_Y], Y_N, Y_SH,
                    bmin[1], bmax[1]);
    zc = axis_cells(grid_reg[REG_GRID_MIN_Z], grid_reg[REG_GRID_MAX_Z], XZ_N, XZ_SH,
                    bmin[2], bmax[2]);
    m.xz = 32'(xc) | (32'(zc) << Z_MASK_OFS);
    m.y = yc[7:0];
    return m;
  endfunction

  // random grid bound, biased to the range edges, to zero and to the box start values
  function automatic logic signed [15:0] pick_bound();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return $urandom_range(0, 1) ? 16'h7FFF - 16'($urandom_range(0, 120))
                                     : 16'h8000 + 16'($urandom_range(0, 120));
      2: return 16'($urandom_range(0, 4000)) - 16'sd2000;
      default: return ($urandom_range(0, 1) ? BOX_INIT : -BOX_INIT)
                      + 16'($urandom_range(0, 80)) - 16'sd40;
    endcase
  endfunction

  // random coordinate near the extremes, the box start values or the grid, or fully random
  function automatic logic signed [15:0] pick_coord(input int axis);
    case ($urandom_range(0, 7))
      0: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      1, 2: return ($urandom_range(0, 1) ? BOX_INIT : -BOX_INIT)
                   + 16'($urandom_range(0, 80)) - 16'sd40;
      3: return grid_reg[REG_GRID_MIN_X + axis] + 16'($urandom_range(0, 600)) - 16'sd300;
      4: return grid_reg[REG_GRID_MAX_X + axis] + 16'($urandom_range(0, 600)) - 16'sd300;
      default: return 16'($urandom);
    endcase
  endfunction

  // surface flags mixing the flag and blocking bits
  function automatic logic [31:0] pick_flags();
    logic [31:0] f;
    if ($urandom_range(0, 3) == 0) begin
      return $urandom;
    end
    f = $urandom & ~(FLAG_ANY | FLAG_NONE);
    if ($urandom_range(0, 2) == 0) f = f | ($urandom & FLAG_ANY);
    if ($urandom_range(0, 1) == 0) f = f | ($urandom & FLAG_NONE);
    return f;
  endfunction

  function automatic facet_t random_facet();
    facet_t f;
    f.v0_x = pick_coord(0);
    f.v0_y = pick_coord(1);
    f.v0_z = pick_coord(2);
    f.v1_x = pick_coord(0);
    f.v1_y = pick_coord(1);
    f.v1_z = pick_coord(2);
    f.v2_x = pick_coord(0);
    f.v2_y = pick_coord(1);
    f.v2_z = pick_coord(2);
    f.surface_flags = pick_flags();
    return f;
  endfunction

  // offer one triangle beat and record its expected masks once taken
  task automatic send_triangle(input facet_t f, input bit typed, input cell_masks_t given);
    int gap;
    if (send_quiet > 0) begin
      send_quiet--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 49) == 0) send_quiet = $urandom_range(20, 60);
      gap = $urandom_range(0, 19);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_v0_x <= f.v0_x;
    in_v0_y <= f.v0_y;
    in_v0_z <= f.v0_z;
    in_v1_x <= f.v1_x;
    in_v1_y <= f.v1_y;
    in_v1_z <= f.v1_z;
    in_v2_x <= f.v2_x;
    in_v2_y <= f.v2_y;
    in_v2_z <= f.v2_z;
    in_surface_flags <= f.surface_flags;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_masks.push_back(typed ? given : bin_triangle(f));
  endtask

  // let every outstanding beat drain before touching the grid
  task automatic settle();
    while (pending_masks.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 1) @(posedge clk);
  endtask

  // one register write; the caller lowers the enable after a group
  task automatic cfg_write(input logic [2:0] addr, input logic [15:0] data);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    if (addr <= REG_GRID_MAX_Z) grid_reg[addr] = data;
  endtask

  // grid setting for one random phase, extremes first
  task automatic program_grid(input int p);
    logic signed [15:0] lo [3], hi [3];
    for (int a = 0; a < 3; a++) begin
      case (p)
        0: begin lo[a] = 16'h8000; hi[a] = 16'h7FFF; end
        1: begin lo[a] = 16'h7FFF; hi[a] = 16'h8000; end
        2: begin lo[a] = 16'h8000; hi[a] = 16'h8000; end
        3: begin lo[a] = 16'h7FFF; hi[a] = 16'h7FFF; end
        4: begin lo[a] = pick_bound(); hi[a] = lo[a]; end
        default: begin
          lo[a] = pick_bound();
          hi[a] = ($urandom_range(0, 2) == 0) ? lo[a] + 16'($urandom_range(0, 400))
                                              : pick_bound();
        end
      endcase
    end
    for (int a = 0; a < 3; a++) begin
      cfg_write(3'(REG_GRID_MIN_X + a), lo[a]);
      cfg_write(3'(REG_GRID_MAX_X + a), hi[a]);
    end
    if ($urandom_range(0, 2) == 0) begin
      cfg_write($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, 16'($urandom));
    end
    cfg_we <= 1'b0;
  endtask

  // result sink: random stalls, quiet stretches and one long hold-off
  initial begin : result_sink
    cell_masks_t want;
    int stall_left;
    int quiet;
    stall_left = 0;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (pending_masks.size() == 0) begin
          $error("result with nothing pending: xz_mask=%h y_mask=%h",
                 out_xz_mask, out_y_mask);
          err_cnt++;
        end else begin
          want = pending_masks.pop_front();
          if (out_xz_mask !== want.xz) begin
            $error("xz_mask: expected %h, got %h", want.xz, out_xz_mask);
            err_cnt++;
          end
          if (out_y_mask !== want.y) begin
            $error("y_mask: expected %h, got %h", want.y, out_y_mask);
            err_cnt++;
          end
        end
        if (quiet > 0) begin
          quiet--;
          stall_left = 0;
        end else begin
          if ($urandom_range(0, 39) == 0) quiet = $urandom_range(20, 60);
          stall_left = $urandom_range(0, 19);
        end
      end
      if (hold_req && !hold_done) begin
        stall_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // main sequence: reset, directed table, random phases, drain
  initial begin : stimulus
    bit writing;
    writing = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        if (!writing) begin
          in_valid <= 1'b0;
          settle();
          writing = 1'b1;
        end
        cfg_write(dir_rows[r].addr, dir_rows[r].data);
      end else begin
        if (writing) begin
          cfg_we <= 1'b0;
          writing = 1'b0;
        end
        send_triangle(dir_rows[r].facet, dir_rows[r].typed, dir_rows[r].masks);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      in_valid <= 1'b0;
      settle();
      program_grid(p);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 2 && n == 60) hold_req = 1'b1;
        send_triangle(random_facet(), 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (pending_masks.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 8) @(posedge clk);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // run limit
  initial begin : watchdog
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

/* files.f */
rtl/tgcm_pkg.sv
rtl/tgcm_box.sv
rtl/tgcm_axis.sv
rtl/triangle_grid_cell_masks.sv
rtl/tgcm_checker.sv
tb/sv/tb_top.sv
